// File: hdl/sstc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstc_pkg: shared types and constants of the series statistics block
// Field widths, trend codes, register indexes and the status bundle that the
// finishing engine returns to the top level.
// ----------------------------------------------------------------------------
package sstc_pkg;

  localparam int VAL_W     = 16;
  localparam int TREND_W   = 3;
  localparam int TOTAL_W   = 13;
  localparam int BAND_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 16'sh7FFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_BAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRONG_BAND = 1'b1;

  localparam logic [BAND_W-1:0] STABLE_BAND_RESET = 7'd5;
  localparam logic [BAND_W-1:0] STRONG_BAND_RESET = 7'd20;

  // Trend codes.
  localparam logic [TREND_W-1:0] TREND_INSUFFICIENT = 3'd0;
  localparam logic [TREND_W-1:0] TREND_STABLE       = 3'd1;
  localparam logic [TREND_W-1:0] TREND_UP           = 3'd2;
  localparam logic [TREND_W-1:0] TREND_STRONG_UP    = 3'd3;
  localparam logic [TREND_W-1:0] TREND_DOWN         = 3'd4;
  localparam logic [TREND_W-1:0] TREND_STRONG_DOWN  = 3'd5;

  // Percent scale after the common factor n is cancelled: 1200 / 2.
  localparam int               PCT_MUL_W = 10;
  localparam logic [PCT_MUL_W-1:0] PCT_SCALE = 10'd600;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VAL_W-1:0]   mean;
    logic [TREND_W-1:0] code;
  } sstc_status_t;

endpackage : sstc_pkg
`default_nettype wire

// File: hdl/sstc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstc_ifs: channel interfaces of the series statistics block
// Sample stream, result stream and configuration write channel, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface sstc_sample_if import sstc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;
  logic                    has_value;
  logic                    last_sample;

  modport source (output valid, output sample_value, output has_value,
                  output last_sample, input ready);
  modport sink   (input valid, input sample_value, input has_value,
                  input last_sample, output ready);
endinterface : sstc_sample_if

interface sstc_result_if import sstc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] peak_value;
  logic signed [VAL_W-1:0] floor_value;
  logic signed [VAL_W-1:0] mean_value;
  logic [TREND_W-1:0]      trend_code;
  logic [TOTAL_W-1:0]      sample_total;

  modport source (output valid, output peak_value, output floor_value,
                  output mean_value, output trend_code, output sample_total,
                  input ready);
  modport sink   (input valid, input peak_value, input floor_value,
                  input mean_value, input trend_code, input sample_total,
                  output ready);
endinterface : sstc_result_if

interface sstc_cfg_if import sstc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BAND_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : sstc_cfg_if
`default_nettype wire

// File: hdl/sstc_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstc_finish: end-of-series engine
// One shared adder, used as shift-add multiplier, restoring divider and
// comparator under a small sequencer, computes the mean and the trend code.
// ----------------------------------------------------------------------------
module sstc_finish import sstc_pkg::*; #(
  parameter int CW = 13,
  parameter int SW = 29,
  parameter int TW = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 slot_free,
  input  logic [CW-1:0]        count,
  input  logic signed [SW-1:0] sum,
  input  logic signed [TW-1:0] prefix,
  input  logic [BAND_W-1:0]    stable_band,
  input  logic [BAND_W-1:0]    strong_band,
  output sstc_status_t         stat
);

  localparam int AW = TW + PCT_MUL_W;
  localparam int QW = SW;
  localparam int KW = $clog2(SW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ABS  = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_MEAN = 4'd3;
  localparam logic [3:0] ST_MULA = 4'd4;
  localparam logic [3:0] ST_SUBT = 4'd5;
  localparam logic [3:0] ST_ABSD = 4'd6;
  localparam logic [3:0] ST_MULL = 4'd7;
  localparam logic [3:0] ST_MULR = 4'd8;
  localparam logic [3:0] ST_MULS = 4'd9;
  localparam logic [3:0] ST_CMPS = 4'd10;
  localparam logic [3:0] ST_MULG = 4'd11;
  localparam logic [3:0] ST_CMPG = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0]         state;
  logic [KW-1:0]      steps;
  logic [AW-1:0]      acc;
  logic [AW-1:0]      mcand;
  logic [QW-1:0]      mplier;
  logic [AW-1:0]      lhs;
  logic [AW-1:0]      r1;
  logic [SW-1:0]      ymag;
  logic               sneg;
  logic               up;
  logic [VAL_W-1:0]   mean;
  logic [TREND_W-1:0] code;

  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_sub;
  logic [AW-1:0] add_sum;
  logic [AW-1:0] mul_res;
  logic          div_bit;
  logic [VAL_W-1:0] quot;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_ABS: begin
        add_b   = AW'(sum);
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = {acc[AW-2:0], mplier[QW-1]};
        add_b   = mcand;
        add_sub = 1'b1;
      end
      ST_MULA, ST_MULL, ST_MULR, ST_MULS, ST_MULG: begin
        add_a = acc;
        add_b = mcand;
      end
      ST_SUBT: begin
        add_a   = acc;
        add_b   = AW'(prefix) <<< 1;
        add_sub = 1'b1;
      end
      ST_ABSD: begin
        add_b   = acc;
        add_sub = 1'b1;
      end
      ST_CMPS: begin
        add_a   = lhs;
        add_b   = acc;
        add_sub = 1'b1;
      end
      ST_CMPG: begin
        add_a   = acc;
        add_b   = lhs;
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum = add_a + (add_b ^ {AW{add_sub}}) + AW'(add_sub);
  assign mul_res = mplier[0] ? add_sum : acc;
  assign div_bit = ~add_sum[AW-1];
  assign quot    = mplier[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (count == '0) begin
              mean  <= '0;
              code  <= TREND_INSUFFICIENT;
              state <= ST_DONE;
            end else begin
              state <= ST_ABS;
            end
          end
        end
        ST_ABS: begin
          sneg   <= sum[SW-1];
          ymag   <= sum[SW-1] ? add_sum[SW-1:0] : sum;
          mplier <= sum[SW-1] ? add_sum[SW-1:0] : sum;
          acc    <= '0;
          mcand  <= AW'(count);
          steps  <= KW'(SW - 1);
          state  <= ST_DIV;
        end
        ST_DIV: begin
          acc    <= div_bit ? add_sum : add_a;
          mplier <= {mplier[QW-2:0], div_bit};
          steps  <= steps - KW'(1);
          if (steps == '0) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean <= sneg ? (VAL_W'(0) - quot) : quot;
          if (count < CW'(2)) begin
            code  <= TREND_INSUFFICIENT;
            state <= ST_DONE;
          end else if (sum == '0) begin
            code  <= TREND_STABLE;
            state <= ST_DONE;
          end else begin
            acc    <= '0;
            mcand  <= AW'(sum);
            mplier <= QW'(count - CW'(1));
            steps  <= KW'(CW - 1);
            state  <= ST_MULA;
          end
        end
        ST_MULA: begin
          acc    <= mul_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          steps  <= steps - KW'(1);
          if (steps == '0) begin
            state <= ST_SUBT;
          end
        end
        ST_SUBT: begin
          // The accumulator now holds (n-1)*sum - 2*prefix, the slope numerator
          // with the common factor n/2 removed.
          acc   <= add_sum;
          state <= ST_ABSD;
        end
        ST_ABSD: begin
          if (acc == '0) begin
            code  <= TREND_STABLE;
            state <= ST_DONE;
          end else begin
            up     <= (acc[AW-1] == sneg);
            mcand  <= acc[AW-1] ? add_sum : acc;
            acc    <= '0;
            mplier <= QW'(PCT_SCALE);
            steps  <= KW'(PCT_MUL_W - 1);
            state  <= ST_MULL;
          end
        end
        ST_MULL: begin
          if (steps == '0) begin
            lhs    <= mul_res;
            acc    <= '0;
            mcand  <= AW'(ymag);
            mplier <= QW'(count) + QW'(1);
            steps  <= KW'(CW);
            state  <= ST_MULR;
          end else begin
            acc    <= mul_res;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            steps  <= steps - KW'(1);
          end
        end
        ST_MULR: begin
          if (steps == '0) begin
            r1     <= mul_res;
            acc    <= '0;
            mcand  <= mul_res;
            mplier <= QW'(stable_band);
            steps  <= KW'(BAND_W - 1);
            state  <= ST_MULS;
          end else begin
            acc    <= mul_res;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            steps  <= steps - KW'(1);
          end
        end
        ST_MULS: begin
          acc    <= mul_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          steps  <= steps - KW'(1);
          if (steps == '0) begin
            state <= ST_CMPS;
          end
        end
        ST_CMPS: begin
          if (add_sum[AW-1]) begin
            code  <= TREND_STABLE;
            state <= ST_DONE;
          end else begin
            acc    <= '0;
            mcand  <= r1;
            mplier <= QW'(strong_band);
            steps  <= KW'(BAND_W - 1);
            state  <= ST_MULG;
          end
        end
        ST_MULG: begin
          acc    <= mul_res;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          steps  <= steps - KW'(1);
          if (steps == '0) begin
            state <= ST_CMPG;
          end
        end
        ST_CMPG: begin
          // A negative difference means the band product is below the change.
          if (up) begin
            code <= add_sum[AW-1] ? TREND_STRONG_UP : TREND_UP;
          end else begin
            code <= add_sum[AW-1] ? TREND_STRONG_DOWN : TREND_DOWN;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    stat.busy = (state != ST_IDLE);
    stat.done = (state == ST_DONE) && slot_free;
    stat.mean = mean;
    stat.code = code;
  end

endmodule : sstc_finish
`default_nettype wire

// File: hdl/series_stats_trend_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// series_stats_trend_classifier_top: series statistics and trend classifier
// Accumulates count, extremes and sums of present samples and, on the last
// sample of a series, reports peak, floor, mean and a least-squares trend code.
// ----------------------------------------------------------------------------
//
//   channel   kind            payload
//   samples   valid/ready in  sample_value, has_value, last_sample
//   results   valid/ready out peak_value, floor_value, mean_value,
//                             trend_code, sample_total
//   cfg       valid/ready in  index, data (always ready)
//
// A sample that is not last leaves the sample channel open; the next one may follow at once.
// A last sample is finished by the shared shift-add/shift-subtract adder of the
// finishing engine, where CW = clog2(MAX_SAMPLES+1) and SW = 16 + CW.
// Reset is synchronous; band registers return to 5 and 20 percent.
// A stalled result register holds the finishing engine in its last state and
// keeps the sample channel closed until the result is taken.
//
module series_stats_trend_classifier_top import sstc_pkg::*; #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  sstc_sample_if.sink     samples,
  sstc_result_if.source   results,
  sstc_cfg_if.sink        cfg
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = VAL_W + CW;
  localparam int TW = VAL_W + 2 * CW;

  logic [BAND_W-1:0]       stable_band;
  logic [BAND_W-1:0]       strong_band;
  logic [CW-1:0]           sample_count;
  logic signed [VAL_W-1:0] running_max;
  logic signed [VAL_W-1:0] running_min;
  logic signed [SW-1:0]    running_sum;
  logic signed [TW-1:0]    prefix_total;
  logic                    pend;
  logic                    accept;
  logic                    slot_free;
  sstc_status_t            fin_stat;

  assign accept    = samples.valid && samples.ready;
  assign samples.ready = !fin_stat.busy && !pend;
  assign slot_free = !results.valid || results.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_band <= STABLE_BAND_RESET;
      strong_band <= STRONG_BAND_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_STABLE_BAND: stable_band <= cfg.data;
        CFG_STRONG_BAND: strong_band <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // The prefix total adds the sum of all earlier samples at each new sample;
  // it replaces the index-weighted sum and needs no multiplier.
  always_ff @(posedge clk) begin
    if (rst || fin_stat.done) begin
      sample_count <= '0;
      running_max  <= VAL_MOST_NEG;
      running_min  <= VAL_MOST_POS;
      running_sum  <= '0;
      prefix_total <= '0;
    end else if (accept && samples.has_value &&
                 (sample_count < CW'(MAX_SAMPLES))) begin
      if (samples.sample_value > running_max) begin
        running_max <= samples.sample_value;
      end
      if (samples.sample_value < running_min) begin
        running_min <= samples.sample_value;
      end
      running_sum  <= running_sum + SW'(samples.sample_value);
      prefix_total <= prefix_total + TW'(running_sum);
      sample_count <= sample_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept && samples.last_sample;
    end
  end

  sstc_finish #(
    .CW (CW),
    .SW (SW),
    .TW (TW)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .start       (pend),
    .slot_free   (slot_free),
    .count       (sample_count),
    .sum         (running_sum),
    .prefix      (prefix_total),
    .stable_band (stable_band),
    .strong_band (strong_band),
    .stat        (fin_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fin_stat.done) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_stat.done) begin
      results.peak_value   <= (sample_count == '0) ? '0 : running_max;
      results.floor_value  <= (sample_count == '0) ? '0 : running_min;
      results.mean_value   <= fin_stat.mean;
      results.trend_code   <= fin_stat.code;
      results.sample_total <= TOTAL_W'(sample_count);
    end
  end

  a_last_starts_engine: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.last_sample) |=> ##1 fin_stat.busy)
    else $error("last sample did not start the finishing engine");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (rst)
    fin_stat.done |-> (!results.valid || results.ready))
    else $error("result written over a pending result");

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    fin_stat.done |=> (results.valid && (sample_count == '0)))
    else $error("finished series left no result or kept its statistics");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(MAX_SAMPLES))
    else $error("sample count went past its limit");

endmodule : series_stats_trend_classifier_top
`default_nettype wire
